// File: rtl/mbce_pkg.sv
// Shared types and constants for the monochrome bitmap color expander.
// No dependencies; every other rtl file imports this package.
`default_nettype none

package mbce_pkg;

  localparam int SIDE_BITS  = 12;   // width of the column/row counters and size registers
  localparam int SIZE_FLD_W = 12;   // bits of a size write that are kept before trimming
  localparam int COORD_W    = 16;
  localparam int COLOR_W    = 16;
  localparam int BYTE_W     = 8;
  localparam int BIT_IDX_W  = $clog2(BYTE_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [COLOR_W-1:0] FG_RESET = 16'hFFFF;
  localparam logic [COLOR_W-1:0] BG_RESET = 16'h0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_WIDTH    = 3'd2,
    REG_HEIGHT   = 3'd3,
    REG_FG_COLOR = 3'd4,
    REG_BG_COLOR = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0]   origin_x;
    logic [COORD_W-1:0]   origin_y;
    logic [SIDE_BITS-1:0] width;
    logic [SIDE_BITS-1:0] height;
    logic [COLOR_W-1:0]   fg_color;
    logic [COLOR_W-1:0]   bg_color;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/mono_bitmap_color_expander.sv
// Top level of the monochrome bitmap color expander.
// Depends on mbce_pkg, mbce_front, mbce_byte_fifo and mbce_back.
`default_nettype none

// Expands a packed 1-bit-per-pixel bitmap, fed one byte per input beat with
// the MSB as the first pixel, into one output beat per pixel at
// (origin_x + column, origin_y + row), row-major over width x height with no
// row padding. Set bits carry the foreground color, clear bits the background
// color; when the two colors are equal clear bits come out with
// write_enable low. A byte yields 8 beats, fewer when the bitmap ends inside
// it (the trailing bits are dropped and the counters rewind), and none at all
// when width or height is zero. Rate: one pixel beat per cycle from the single
// expansion step of the back end while the output register is free or popped;
// a queued next byte follows the last pixel of its predecessor with no gap.
// An input beat passes the byte queue and the shifter on its way to the output
// register. A two-entry byte queue sits between input and expansion, and a
// registered output stage decouples pop from the expander. Configuration writes
// go straight into registers and must only be issued while the block is idle.
module mono_bitmap_color_expander import mbce_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [BYTE_W-1:0]     in_bitmap_byte,
  output logic                       empty,
  input  wire logic                  pop,
  output logic signed [COORD_W-1:0]  out_pixel_x,
  output logic signed [COORD_W-1:0]  out_pixel_y,
  output logic [COLOR_W-1:0]         out_pixel_color,
  output logic                       out_write_enable,
  output logic                       out_last_of_byte,
  output logic                       out_last_of_bitmap
);

  cfg_t              cfg;
  logic              q_push, q_full, q_pop, q_empty;
  logic [BYTE_W-1:0] q_wdata, q_rdata;

  // front: config registers, takes every beat the queue has room for
  mbce_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_push        (push),
    .in_full        (full),
    .in_bitmap_byte (in_bitmap_byte),
    .cfg            (cfg),
    .q_push         (q_push),
    .q_wdata        (q_wdata),
    .q_full         (q_full)
  );

  // bytes for a non-empty bitmap wait here
  mbce_byte_fifo u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // back: one pixel per cycle into the output register while it is free or popped
  mbce_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .q_rdata            (q_rdata),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .out_empty          (empty),
    .out_pop            (pop),
    .out_pixel_x        (out_pixel_x),
    .out_pixel_y        (out_pixel_y),
    .out_pixel_color    (out_pixel_color),
    .out_write_enable   (out_write_enable),
    .out_last_of_byte   (out_last_of_byte),
    .out_last_of_bitmap (out_last_of_bitmap)
  );

endmodule

`default_nettype wire

// File: rtl/mbce_front.sv
// Front end: configuration registers and input beat classification.
// Depends on mbce_pkg.
`default_nettype none

module mbce_front import mbce_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire logic [BYTE_W-1:0]     in_bitmap_byte,
  output cfg_t                       cfg,
  output logic                       q_push,
  output logic [BYTE_W-1:0]          q_wdata,
  input  wire logic                  q_full
);

  cfg_t cfg_r, cfg_nxt;
  logic accept;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X: cfg_nxt.origin_x = cfg_wdata[COORD_W-1:0];
        REG_ORIGIN_Y: cfg_nxt.origin_y = cfg_wdata[COORD_W-1:0];
        REG_WIDTH:    cfg_nxt.width    = SIDE_BITS'(cfg_wdata[SIZE_FLD_W-1:0]);
        REG_HEIGHT:   cfg_nxt.height   = SIDE_BITS'(cfg_wdata[SIZE_FLD_W-1:0]);
        REG_FG_COLOR: cfg_nxt.fg_color = cfg_wdata[COLOR_W-1:0];
        REG_BG_COLOR: cfg_nxt.bg_color = cfg_wdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x <= '0;
      cfg_r.origin_y <= '0;
      cfg_r.width    <= '0;
      cfg_r.height   <= '0;
      cfg_r.fg_color <= FG_RESET;
      cfg_r.bg_color <= BG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // empty bitmap: the beat is taken and dropped, it yields no pixels
  assign accept  = in_push && !q_full;
  assign in_full = q_full;
  assign q_push  = accept && (cfg_r.width != '0) && (cfg_r.height != '0);
  assign q_wdata = in_bitmap_byte;
  assign cfg     = cfg_r;

endmodule

`default_nettype wire

// File: rtl/mbce_byte_fifo.sv
// Short byte queue between front and back end.
// Depends on mbce_pkg.
`default_nettype none

module mbce_byte_fifo import mbce_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [BYTE_W-1:0] wdata,
  output logic                   full,
  input  wire logic              pop,
  output logic [BYTE_W-1:0]      rdata,
  output logic                   empty
);

  logic [BYTE_W-1:0] slots_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

// File: rtl/mbce_back.sv
// Back end: walks each queued byte bit by bit, keeps the column/row
// counters and drives the output register. Depends on mbce_pkg.
`default_nettype none

module mbce_back import mbce_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic [BYTE_W-1:0]  q_rdata,
  input  wire logic               q_empty,
  output logic                    q_pop,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic signed [COORD_W-1:0] out_pixel_x,
  output logic signed [COORD_W-1:0] out_pixel_y,
  output logic [COLOR_W-1:0]      out_pixel_color,
  output logic                    out_write_enable,
  output logic                    out_last_of_byte,
  output logic                    out_last_of_bitmap
);

  logic                 busy_r;
  logic [BYTE_W-1:0]    sh_r;
  logic [BIT_IDX_W-1:0] idx_r;
  logic [SIDE_BITS-1:0] col_r, row_r;

  logic                 ovld_r;
  logic [COORD_W-1:0]   ox_r, oy_r;
  logic [COLOR_W-1:0]   ocol_r;
  logic                 owe_r, olb_r, olbm_r;

  logic adv, step, col_wrap, row_wrap, end_bmp, last_byte, bit_set;

  assign adv      = !ovld_r || out_pop;
  assign step     = busy_r && adv;
  assign bit_set  = sh_r[BYTE_W-1];
  assign col_wrap = ({1'b0, col_r} + 1'b1) >= {1'b0, cfg.width};
  assign row_wrap = ({1'b0, row_r} + 1'b1) >= {1'b0, cfg.height};
  assign end_bmp  = col_wrap && row_wrap;
  assign last_byte = end_bmp || (idx_r == BIT_IDX_W'(BYTE_W - 1));
  assign q_pop    = !q_empty && (!busy_r || (step && last_byte));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      col_r  <= '0;
      row_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      if (step) begin
        if (col_wrap) begin
          col_r <= '0;
          row_r <= row_wrap ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      if (q_pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (step) begin
        busy_r <= !last_byte;
        idx_r  <= last_byte ? '0 : idx_r + 1'b1;
      end
      if (step) begin
        ovld_r <= 1'b1;
      end else if (out_pop) begin
        ovld_r <= 1'b0;
      end
    end
  end

  // payload: byte shifter and output beat
  always_ff @(posedge clk) begin
    if (q_pop) begin
      sh_r <= q_rdata;
    end else if (step) begin
      sh_r <= {sh_r[BYTE_W-2:0], 1'b0};
    end
    if (step) begin
      ox_r   <= cfg.origin_x + COORD_W'(col_r);
      oy_r   <= cfg.origin_y + COORD_W'(row_r);
      ocol_r <= bit_set ? cfg.fg_color : cfg.bg_color;
      owe_r  <= bit_set || (cfg.fg_color != cfg.bg_color);
      olb_r  <= last_byte;
      olbm_r <= end_bmp;
    end
  end

  assign out_empty          = !ovld_r;
  assign out_pixel_x        = ox_r;
  assign out_pixel_y        = oy_r;
  assign out_pixel_color    = ocol_r;
  assign out_write_enable   = owe_r;
  assign out_last_of_byte   = olb_r;
  assign out_last_of_bitmap = olbm_r;

  a_bmp_ends_byte: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && olbm_r |-> olb_r)
    else $error("end of bitmap without end of byte");

  a_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    step && end_bmp |=> (col_r == '0) && (row_r == '0))
    else $error("counters did not rewind after last pixel");

  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (idx_r == '0))
    else $error("bit index left nonzero while idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && !out_pop |=> ovld_r && $stable(ox_r) && $stable(olb_r))
    else $error("pending output beat overwritten");

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for mono_bitmap_color_expander: pushes packed bitmap bytes and
// checks every pixel beat against a cycle-free expansion of the same bytes.
// Depends on mbce_pkg and the rtl top level only.
`timescale 1ns / 100ps

module testbench;
  import mbce_pkg::*;

  // Register index that the block does not decode; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam int HOLD_CYCLES     = 300;   // long receiver hold-off, fills the byte queue
  localparam int SETTLE_CYCLES   = 16;    // drain margin for bytes that yield no pixels
  localparam int WATCHDOG_LIMIT  = 2000;  // cycles without any accepted beat
  localparam int IDLE_PCT        = 13;
  localparam int RANDOM_PHASES   = 7;
  localparam int BYTES_PER_PHASE = 23;

  // One pixel beat as seen on the result side.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [COLOR_W-1:0]        color;
    logic                      wr_en;
    logic                      last_byte;
    logic                      last_bitmap;
  } pixel_t;

  // Expands accepted bytes into expected pixel beats and checks the beats that come out.
  // Holds its own copy of the registers and of the column/row counters.
  class pixel_scoreboard;
    logic [COORD_W-1:0]   org_x, org_y;
    logic [SIDE_BITS-1:0] wid, hgt;
    logic [COLOR_W-1:0]   fg, bg;
    logic [SIDE_BITS-1:0] col, row;
    pixel_t               expected_pixels[$];
    int                   errors;

    function new();
      org_x  = '0;
      org_y  = '0;
      wid    = '0;
      hgt    = '0;
      fg     = FG_RESET;
      bg     = BG_RESET;
      col    = '0;
      row    = '0;
      errors = 0;
    endfunction

    // Register writes leave the counters alone.
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ORIGIN_X: org_x = val;
        REG_ORIGIN_Y: org_y = val;
        REG_WIDTH:    wid   = val[SIDE_BITS-1:0];
        REG_HEIGHT:   hgt   = val[SIDE_BITS-1:0];
        REG_FG_COLOR: fg    = val;
        REG_BG_COLOR: bg    = val;
        default: ;
      endcase
    endfunction

    // MSB first; stops early when the bitmap ends inside the byte.
    function void note_byte(logic [BYTE_W-1:0] b);
      logic   transparent;
      logic   done;
      pixel_t p;
      transparent = (fg == bg);
      if (wid == 0 || hgt == 0)
        return;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
        p.x     = org_x + COORD_W'(col);
        p.y     = org_y + COORD_W'(row);
        p.color = b[i] ? fg : bg;
        p.wr_en = b[i] || !transparent;
        done    = 1'b0;
        // counters past a shrunk size wrap or end the bitmap, hence >=
        if (int'(col) + 1 >= int'(wid)) begin
          col = '0;
          if (int'(row) + 1 >= int'(hgt)) begin
            row  = '0;
            done = 1'b1;
          end else begin
            row = row + 1'b1;
          end
        end else begin
          col = col + 1'b1;
        end
        p.last_bitmap = done;
        p.last_byte   = done || (i == 0);
        expected_pixels.push_back(p);
        if (done)
          break;
      end
    endfunction

    function void complain(string what, pixel_t exp_p, pixel_t got);
      errors++;
      if (errors <= 10)
        $display("%s: exp x=%0d y=%0d c=%h we=%b lb=%b lbm=%b | got x=%0d y=%0d c=%h we=%b lb=%b lbm=%b",
                 what, exp_p.x, exp_p.y, exp_p.color, exp_p.wr_en, exp_p.last_byte,
                 exp_p.last_bitmap, got.x, got.y, got.color, got.wr_en, got.last_byte,
                 got.last_bitmap);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t exp_p;
      if (expected_pixels.size() == 0) begin
        complain("pixel beat with nothing expected", '0, got);
        return;
      end
      exp_p = expected_pixels.pop_front();
      if (got.x !== exp_p.x || got.y !== exp_p.y || got.color !== exp_p.color ||
          got.wr_en !== exp_p.wr_en || got.last_byte !== exp_p.last_byte ||
          got.last_bitmap !== exp_p.last_bitmap)
        complain("pixel mismatch", exp_p, got);
    endfunction

    function int outstanding();
      return expected_pixels.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata      = '0;
  logic                  push           = 1'b0;
  logic                  full;
  logic [BYTE_W-1:0]     in_bitmap_byte = '0;
  logic                  empty;
  logic                  pop            = 1'b0;
  logic signed [COORD_W-1:0] out_pixel_x;
  logic signed [COORD_W-1:0] out_pixel_y;
  logic [COLOR_W-1:0]    out_pixel_color;
  logic                  out_write_enable;
  logic                  out_last_of_byte;
  logic                  out_last_of_bitmap;

  mono_bitmap_color_expander dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .push              (push),
    .full              (full),
    .in_bitmap_byte    (in_bitmap_byte),
    .empty             (empty),
    .pop               (pop),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pixel_color   (out_pixel_color),
    .out_write_enable  (out_write_enable),
    .out_last_of_byte  (out_last_of_byte),
    .out_last_of_bitmap(out_last_of_bitmap)
  );

  pixel_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hold_request is shared between sender and receiver; bytes_sent is the sender's own.
  logic hold_request = 1'b0;   // sender asks the receiver for one long hold-off
  int   bytes_sent   = 0;

  // ---------------------------------------------------------------------------
  // Config and input drivers. All signals change by NBA right after an edge,
  // and the DUT outputs are read at the edge, before its flops update.
  // ---------------------------------------------------------------------------

  // Leaves cfg_we high so back-to-back writes never double-drive it in one step.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_config(input logic [15:0] ox, input logic [15:0] oy,
                            input logic [15:0] w, input logic [15:0] h,
                            input logic [15:0] fgc, input logic [15:0] bgc);
    cfg_write(REG_ORIGIN_X, ox);
    cfg_write(REG_ORIGIN_Y, oy);
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_FG_COLOR, fgc);
    cfg_write(REG_BG_COLOR, bgc);
    cfg_we <= 1'b0;
  endtask

  // Random idle beats ahead of the byte, except in the calm stretch.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    bit calm;
    calm = (bytes_sent >= 60 && bytes_sent < 110);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      push           <= 1'b0;
      in_bitmap_byte <= BYTE_W'($urandom);
      @(posedge clk);
    end
    push           <= 1'b1;
    in_bitmap_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // Block must be idle before the next register write: all pixels back, plus a
  // margin for queued bytes that produce nothing.
  task automatic drain();
    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_origin();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly small sides; sometimes zero or near the top. Upper write bits are junk
  // the block must drop.
  function automatic logic [15:0] pick_side(int small_max, bit allow_odd);
    logic [SIDE_BITS-1:0] s;
    int sel;
    sel = $urandom_range(7);
    if (allow_odd && sel == 0)
      s = '0;
    else if (allow_odd && sel == 1)
      s = SIDE_BITS'($urandom_range(4095, 4000));
    else
      s = SIDE_BITS'($urandom_range(small_max, 1));
    return {4'($urandom), s};
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] fgc;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty bitmap at reset sizes: bytes vanish; spare index write is a no-op
    cfg_write(REG_SPARE, 16'hFFFF);
    cfg_we <= 1'b0;
    send_byte(8'hFF);
    send_byte(8'h00);
    drain();

    // 3x2 bitmap ends inside a byte; origins at the wrap points, inverted colors
    set_config(16'h7FFF, 16'h8000, 16'hF003, 16'h0002, 16'h0000, 16'hFFFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hA5);
    drain();

    // largest bitmap, transparent clear bits
    set_config(16'h0000, 16'hFFFF, 16'h0FFF, 16'h0FFF, 16'h1234, 16'h1234);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'h81);
    drain();

    // 1x1: every byte is one whole bitmap
    set_config(16'h8000, 16'h7FFF, 16'h0001, 16'h0001, 16'hFFFF, 16'h0000);
    send_byte(8'h80);
    send_byte(8'h7F);
    drain();

    // counters left past a shrunk size: column wraps, row ends the bitmap
    set_config(16'h0010, 16'h0020, 16'h0014, 16'h0005, 16'hF800, 16'h07E0);
    send_byte(8'hC3);
    send_byte(8'h3C);
    send_byte(8'h96);
    drain();
    set_config(16'h0010, 16'h0020, 16'h0003, 16'h0001, 16'hF800, 16'h07E0);
    send_byte(8'h69);
    send_byte(8'hF0);
    drain();

    // random phases; the first is non-empty and carries the long hold-off
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      fgc = 16'($urandom);
      set_config(pick_origin(), pick_origin(), pick_side(12, ph != 0), pick_side(6, ph != 0),
                 fgc, ($urandom_range(2) == 0) ? fgc : 16'($urandom));
      for (int k = 0; k < BYTES_PER_PHASE; k++) begin
        if (ph == 0 && k == 2)
          hold_request <= 1'b1;
        send_byte(pick_byte());
      end
      drain();
    end

    if (sb.outstanding() != 0)
      sb.errors += sb.outstanding();
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: checks each popped beat, idles at random, and once holds off for
  // a long stretch so the queue backs up into full.
  // ---------------------------------------------------------------------------
  initial begin
    int  pixels_seen;
    int  hold_left;
    bit  hold_used;
    bit  calm;
    pixel_t got;
    pixels_seen = 0;
    hold_left   = 0;
    hold_used   = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        got.x           = out_pixel_x;
        got.y           = out_pixel_y;
        got.color       = out_pixel_color;
        got.wr_en       = out_write_enable;
        got.last_byte   = out_last_of_byte;
        got.last_bitmap = out_last_of_bitmap;
        sb.check_pixel(got);
        pixels_seen++;
      end
      calm = (pixels_seen >= 300 && pixels_seen < 700);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_request && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        pop <= 1'b0;
      end else begin
        pop <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: ends a hung run when nothing moves on either side for too long.
  initial begin
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
